FILE: rtl/core/dpe_pkg.sv
`timescale 1ns / 1ps

package dpe_pkg;

    // fixed point format of every stored value
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIV_BITS  = DATA_W + FRAC_BITS;
    localparam int CORDIC_W  = 34;
    localparam int CORDIC_N  = 30;
    localparam int TRIG_SHR  = 30 - FRAC_BITS;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam logic signed [CORDIC_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = 34'sd652032874;

    // pi in the stored format and the wrap period
    localparam int PI_F       = 205887;
    localparam int WRAP_M     = 2 * PI_F;
    localparam int WRAP_STEPS = 14;

    localparam int PC_W       = 6;
    localparam logic [PC_W-1:0] POS_PC     = 6'd44;
    localparam logic [PC_W-1:0] RESTART_PC = 6'd53;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_WRAP,
        OP_SINCOS,
        OP_JUMP,
        OP_END
    } op_t;

    typedef enum logic [4:0] {
        ID_ZERO, ID_A1, ID_A2, ID_R1, ID_R2, ID_G, ID_L1, ID_L2, ID_U, ID_DT,
        ID_SA1, ID_SA2, ID_S1, ID_C1, ID_S2, ID_C2, ID_SD, ID_CD, ID_W1, ID_W2,
        ID_DEN, ID_T0, ID_T1, ID_T2, ID_T3, ID_JX, ID_JY, ID_TX, ID_TY
    } reg_id_t;

    typedef enum logic [2:0] {
        CFG_GRAVITY,
        CFG_UPPER_LENGTH,
        CFG_LOWER_LENGTH,
        CFG_UPPER_MASS,
        CFG_LOWER_MASS,
        CFG_UPPER_START,
        CFG_LOWER_START
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        op_t     op;
        reg_id_t a;
        reg_id_t b;
        reg_id_t dst;
        reg_id_t dst2;
    } ucmd_t;

    typedef struct packed {
        logic  go;
        logic  start_item;
        ucmd_t cmd;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic busy;
    } dp_status_t;

    typedef struct packed {
        logic        [22:0] gravity;
        logic        [22:0] upper_length;
        logic        [22:0] lower_length;
        logic        [22:0] upper_mass;
        logic        [22:0] lower_mass;
        logic signed [18:0] upper_start_angle;
        logic signed [18:0] lower_start_angle;
    } cfg_t;

    typedef struct packed {
        logic signed [18:0] upper_angle;
        logic signed [18:0] lower_angle;
        logic signed [31:0] upper_rate;
        logic signed [31:0] lower_rate;
        logic signed [31:0] joint_x;
        logic signed [31:0] joint_y;
        logic signed [31:0] tip_x;
        logic signed [31:0] tip_y;
        logic               overflow;
    } res_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'h3243F6A8;
            5'd1:  r = 30'h1DAC6705;
            5'd2:  r = 30'h0FADBAFC;
            5'd3:  r = 30'h07F56EA6;
            5'd4:  r = 30'h03FEAB76;
            5'd5:  r = 30'h01FFD55B;
            5'd6:  r = 30'h00FFFAAA;
            5'd7:  r = 30'h007FFF55;
            5'd8:  r = 30'h003FFFEA;
            5'd9:  r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000007;
            5'd28: r = 30'h00000003;
            5'd29: r = 30'h00000001;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic ucmd_t mk(input op_t op, input reg_id_t a, input reg_id_t b,
                                 input reg_id_t dst, input reg_id_t dst2);
        ucmd_t c;
        c.op   = op;
        c.a    = a;
        c.b    = b;
        c.dst  = dst;
        c.dst2 = dst2;
        return c;
    endfunction

    // step program: advance from 0, positions from POS_PC, restart from RESTART_PC
    function automatic ucmd_t ucode(input logic [PC_W-1:0] pc);
        ucmd_t c;
        unique case (pc)
            6'd0:  c = mk(OP_SINCOS, ID_A1, ID_ZERO, ID_S1, ID_C1);
            6'd1:  c = mk(OP_SINCOS, ID_A2, ID_ZERO, ID_S2, ID_C2);
            6'd2:  c = mk(OP_SUB, ID_A1, ID_A2, ID_T0, ID_ZERO);
            6'd3:  c = mk(OP_WRAP, ID_T0, ID_ZERO, ID_T0, ID_ZERO);
            6'd4:  c = mk(OP_SINCOS, ID_T0, ID_ZERO, ID_SD, ID_CD);
            6'd5:  c = mk(OP_MUL, ID_R1, ID_R1, ID_W1, ID_ZERO);
            6'd6:  c = mk(OP_MUL, ID_R2, ID_R2, ID_W2, ID_ZERO);
            6'd7:  c = mk(OP_MUL, ID_CD, ID_CD, ID_T0, ID_ZERO);
            6'd8:  c = mk(OP_SUB, ID_U, ID_T0, ID_DEN, ID_ZERO);
            6'd9:  c = mk(OP_MUL, ID_S2, ID_CD, ID_T0, ID_ZERO);
            6'd10: c = mk(OP_MUL, ID_U, ID_S1, ID_T1, ID_ZERO);
            6'd11: c = mk(OP_SUB, ID_T0, ID_T1, ID_T0, ID_ZERO);
            6'd12: c = mk(OP_MUL, ID_G, ID_T0, ID_T0, ID_ZERO);
            6'd13: c = mk(OP_MUL, ID_L2, ID_W2, ID_T1, ID_ZERO);
            6'd14: c = mk(OP_MUL, ID_L1, ID_W1, ID_T2, ID_ZERO);
            6'd15: c = mk(OP_MUL, ID_T2, ID_CD, ID_T2, ID_ZERO);
            6'd16: c = mk(OP_ADD, ID_T1, ID_T2, ID_T1, ID_ZERO);
            6'd17: c = mk(OP_MUL, ID_T1, ID_SD, ID_T1, ID_ZERO);
            6'd18: c = mk(OP_SUB, ID_T0, ID_T1, ID_T0, ID_ZERO);
            6'd19: c = mk(OP_MUL, ID_G, ID_U, ID_T1, ID_ZERO);
            6'd20: c = mk(OP_MUL, ID_S1, ID_CD, ID_T2, ID_ZERO);
            6'd21: c = mk(OP_SUB, ID_T2, ID_S2, ID_T2, ID_ZERO);
            6'd22: c = mk(OP_MUL, ID_T1, ID_T2, ID_T1, ID_ZERO);
            6'd23: c = mk(OP_MUL, ID_U, ID_L1, ID_T2, ID_ZERO);
            6'd24: c = mk(OP_MUL, ID_T2, ID_W1, ID_T2, ID_ZERO);
            6'd25: c = mk(OP_MUL, ID_L2, ID_W2, ID_T3, ID_ZERO);
            6'd26: c = mk(OP_MUL, ID_T3, ID_CD, ID_T3, ID_ZERO);
            6'd27: c = mk(OP_ADD, ID_T2, ID_T3, ID_T2, ID_ZERO);
            6'd28: c = mk(OP_MUL, ID_T2, ID_SD, ID_T2, ID_ZERO);
            6'd29: c = mk(OP_ADD, ID_T1, ID_T2, ID_T1, ID_ZERO);
            6'd30: c = mk(OP_MUL, ID_L1, ID_DEN, ID_T2, ID_ZERO);
            6'd31: c = mk(OP_DIV, ID_T0, ID_T2, ID_T0, ID_ZERO);
            6'd32: c = mk(OP_MUL, ID_L2, ID_DEN, ID_T2, ID_ZERO);
            6'd33: c = mk(OP_DIV, ID_T1, ID_T2, ID_T1, ID_ZERO);
            6'd34: c = mk(OP_MUL, ID_T0, ID_DT, ID_T0, ID_ZERO);
            6'd35: c = mk(OP_ADD, ID_R1, ID_T0, ID_R1, ID_ZERO);
            6'd36: c = mk(OP_MUL, ID_T1, ID_DT, ID_T1, ID_ZERO);
            6'd37: c = mk(OP_ADD, ID_R2, ID_T1, ID_R2, ID_ZERO);
            6'd38: c = mk(OP_MUL, ID_R1, ID_DT, ID_T0, ID_ZERO);
            6'd39: c = mk(OP_ADD, ID_A1, ID_T0, ID_T0, ID_ZERO);
            6'd40: c = mk(OP_WRAP, ID_T0, ID_ZERO, ID_A1, ID_ZERO);
            6'd41: c = mk(OP_MUL, ID_R2, ID_DT, ID_T1, ID_ZERO);
            6'd42: c = mk(OP_ADD, ID_A2, ID_T1, ID_T1, ID_ZERO);
            6'd43: c = mk(OP_WRAP, ID_T1, ID_ZERO, ID_A2, ID_ZERO);
            6'd44: c = mk(OP_SINCOS, ID_A1, ID_ZERO, ID_S1, ID_C1);
            6'd45: c = mk(OP_SINCOS, ID_A2, ID_ZERO, ID_S2, ID_C2);
            6'd46: c = mk(OP_MUL, ID_L1, ID_S1, ID_JX, ID_ZERO);
            6'd47: c = mk(OP_MUL, ID_L1, ID_C1, ID_JY, ID_ZERO);
            6'd48: c = mk(OP_MUL, ID_L2, ID_S2, ID_TX, ID_ZERO);
            6'd49: c = mk(OP_ADD, ID_JX, ID_TX, ID_TX, ID_ZERO);
            6'd50: c = mk(OP_MUL, ID_L2, ID_C2, ID_TY, ID_ZERO);
            6'd51: c = mk(OP_ADD, ID_JY, ID_TY, ID_TY, ID_ZERO);
            6'd53: c = mk(OP_WRAP, ID_SA1, ID_ZERO, ID_A1, ID_ZERO);
            6'd54: c = mk(OP_WRAP, ID_SA2, ID_ZERO, ID_A2, ID_ZERO);
            6'd55: c = mk(OP_SUB, ID_ZERO, ID_ZERO, ID_R1, ID_ZERO);
            6'd56: c = mk(OP_SUB, ID_ZERO, ID_ZERO, ID_R2, ID_ZERO);
            6'd57: c = mk(OP_JUMP, ID_ZERO, ID_ZERO, ID_ZERO, ID_ZERO);
            default: c = mk(OP_END, ID_ZERO, ID_ZERO, ID_ZERO, ID_ZERO);
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/double_pendulum_euler_step_unit.sv
`timescale 1ns / 1ps
// one beat at a time; an advance beat runs five sine/cosine pairs on the
// shared cordic and two divisions on the radix-2 divider
// reset: rst_n clears angles, rates and control at once; registers take defaults

module double_pendulum_euler_step_unit (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // frame_time [13:0], zero pad [15:14]
    input  logic         s_tuser,   // req_type
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // upper_angle, lower_angle, upper_rate, lower_rate, joint_x, joint_y,
    // tip_x, tip_y from bit 0 up, zero pad [231:230]
    output logic [231:0] m_tdata,
    output logic         m_tuser,   // overflow
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [22:0]  cfg_data
);
    import dpe_pkg::*;

    cfg_t       cfg_reg;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    res_t       result;
    logic       out_free;
    logic       finish;

    logic         m_tvalid_reg;
    logic [231:0] m_tdata_reg;
    logic         m_tuser_reg;

    // registers are always writable, the block is idle by contract
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity           <= 23'd642908;
            cfg_reg.upper_length      <= 23'd65536;
            cfg_reg.lower_length      <= 23'd65536;
            cfg_reg.upper_mass        <= 23'd65536;
            cfg_reg.lower_mass        <= 23'd65536;
            cfg_reg.upper_start_angle <= '0;
            cfg_reg.lower_start_angle <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GRAVITY:      cfg_reg.gravity           <= cfg_data;
                CFG_UPPER_LENGTH: cfg_reg.upper_length      <= cfg_data;
                CFG_LOWER_LENGTH: cfg_reg.lower_length      <= cfg_data;
                CFG_UPPER_MASS:   cfg_reg.upper_mass        <= cfg_data;
                CFG_LOWER_MASS:   cfg_reg.lower_mass        <= cfg_data;
                CFG_UPPER_START:  cfg_reg.upper_start_angle <= cfg_data[18:0];
                CFG_LOWER_START:  cfg_reg.lower_start_angle <= cfg_data[18:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // output register lets the next beat start while a result waits
    assign out_free = !m_tvalid_reg || m_tready;

    dpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .req_type  (s_tuser),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .finish    (finish),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    dpe_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .frame_time (s_tdata[13:0]),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (finish)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            m_tdata_reg <= {2'b00, result.tip_y, result.tip_x, result.joint_y,
                            result.joint_x, result.lower_rate, result.upper_rate,
                            result.lower_angle, result.upper_angle};
            m_tuser_reg <= result.overflow;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/core/dpe_ctrl.sv
`timescale 1ns / 1ps

module dpe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               req_type,
    output logic               in_ready,
    input  logic               out_free,
    output logic               finish,
    output dpe_pkg::dp_cmd_t   dp_cmd,
    input  dpe_pkg::dp_status_t dp_status
);
    import dpe_pkg::*;

    ctrl_state_t     state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ucmd_t           ucmd;

    assign ucmd = ucode(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ISSUE;
                    pc_next    = req_type ? RESTART_PC : '0;
                end
            end
            ST_ISSUE:
            begin
                if (ucmd.op == OP_END)
                    state_next = ST_FINISH;
                else if (ucmd.op == OP_JUMP)
                    pc_next = POS_PC;
                else
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (dp_status.done)
                begin
                    state_next = ST_ISSUE;
                    pc_next    = pc_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready          = (state_reg == ST_IDLE);
        finish            = (state_reg == ST_FINISH) && out_free;
        dp_cmd.start_item = (state_reg == ST_IDLE) && in_valid;
        dp_cmd.go         = (state_reg == ST_ISSUE) && !dp_status.busy
                            && (ucmd.op != OP_END) && (ucmd.op != OP_JUMP);
        dp_cmd.cmd        = ucmd;
    end

endmodule

FILE: rtl/core/dpe_datapath.sv
`timescale 1ns / 1ps

module dpe_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  dpe_pkg::cfg_t       cfg,
    input  logic [13:0]         frame_time,
    input  dpe_pkg::dp_cmd_t    dp_cmd,
    output dpe_pkg::dp_status_t dp_status,
    output dpe_pkg::res_t       result
);
    import dpe_pkg::*;

    // state and scratch values
    logic signed [DATA_W-1:0] a1_reg, a2_reg, r1_reg, r2_reg;
    logic signed [DATA_W-1:0] s1_reg, c1_reg, s2_reg, c2_reg, sd_reg, cd_reg;
    logic signed [DATA_W-1:0] w1_reg, w2_reg, den_reg;
    logic signed [DATA_W-1:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic signed [DATA_W-1:0] jx_reg, jy_reg, tx_reg, ty_reg;
    logic signed [DATA_W-1:0] u_reg, dt_reg;

    // operation control
    ucmd_t       cmd_reg;
    logic        run_reg;
    logic [5:0]  cnt_reg;
    logic [5:0]  last_cnt;
    logic        ovf_reg;

    logic signed [DATA_W-1:0]   src_vec [0:31];
    logic signed [DATA_W-1:0]   op_a, op_b;
    logic signed [DATA_W-1:0]   a_reg, b_reg;
    logic signed [2*DATA_W-1:0] prod_reg, prod_next;

    // divider
    logic [DATA_W-1:0]   dvs_reg, rem_reg, rem_next;
    logic [DIV_BITS-1:0] quot_reg, quot_next;
    logic                qneg_reg, dz_reg;
    logic [DATA_W:0]     div_shift;
    logic                div_ge;
    logic [DATA_W-1:0]   n_mag, d_mag;

    // wrap reducer
    logic [CORDIC_W-1:0] wt_reg, wt_next, w_thr;

    // cordic
    logic signed [CORDIC_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [CORDIC_W-1:0] cx_next, cy_next, cz_next;
    logic signed [CORDIC_W-1:0] z0, xs, ys, at;
    logic signed [CORDIC_W-1:0] sin_full, cos_full;
    logic                       neg_reg;

    // write back
    logic                       wr_en, wr2_en, wr_ovf;
    logic signed [DATA_W-1:0]   wr_val, wr2_val;
    logic signed [DIV_BITS-1:0] mul_q;
    logic signed [DATA_W:0]     sum_s;

    always_comb
    begin
        for (int i = 0; i < 32; i++)
            src_vec[i] = '0;
        src_vec[ID_A1]  = a1_reg;
        src_vec[ID_A2]  = a2_reg;
        src_vec[ID_R1]  = r1_reg;
        src_vec[ID_R2]  = r2_reg;
        src_vec[ID_G]   = $signed({9'b0, cfg.gravity});
        src_vec[ID_L1]  = $signed({9'b0, cfg.upper_length});
        src_vec[ID_L2]  = $signed({9'b0, cfg.lower_length});
        src_vec[ID_U]   = u_reg;
        src_vec[ID_DT]  = dt_reg;
        src_vec[ID_SA1] = DATA_W'(cfg.upper_start_angle);
        src_vec[ID_SA2] = DATA_W'(cfg.lower_start_angle);
        src_vec[ID_S1]  = s1_reg;
        src_vec[ID_C1]  = c1_reg;
        src_vec[ID_S2]  = s2_reg;
        src_vec[ID_C2]  = c2_reg;
        src_vec[ID_SD]  = sd_reg;
        src_vec[ID_CD]  = cd_reg;
        src_vec[ID_W1]  = w1_reg;
        src_vec[ID_W2]  = w2_reg;
        src_vec[ID_DEN] = den_reg;
        src_vec[ID_T0]  = t0_reg;
        src_vec[ID_T1]  = t1_reg;
        src_vec[ID_T2]  = t2_reg;
        src_vec[ID_T3]  = t3_reg;
        src_vec[ID_JX]  = jx_reg;
        src_vec[ID_JY]  = jy_reg;
        src_vec[ID_TX]  = tx_reg;
        src_vec[ID_TY]  = ty_reg;
    end

    assign op_a = src_vec[dp_cmd.cmd.a];
    assign op_b = src_vec[dp_cmd.cmd.b];

    always_comb
    begin
        unique case (cmd_reg.op)
            OP_MUL:    last_cnt = 6'd1;
            OP_DIV:    last_cnt = 6'(DIV_BITS);
            OP_WRAP:   last_cnt = 6'(WRAP_STEPS);
            OP_SINCOS: last_cnt = 6'(CORDIC_N);
            default:   last_cnt = 6'd0;
        endcase
    end

    assign wr_en  = run_reg && (cnt_reg == last_cnt);
    assign wr2_en = wr_en && (cmd_reg.op == OP_SINCOS);

    assign dp_status.done = wr_en;
    assign dp_status.busy = run_reg;

    // operand magnitudes for the divider
    assign n_mag = op_a[DATA_W-1] ? DATA_W'(-op_a) : DATA_W'(op_a);
    assign d_mag = op_b[DATA_W-1] ? DATA_W'(-op_b) : DATA_W'(op_b);

    // angle scaled to the cordic format, folded into [-pi/2, pi/2] at issue
    assign z0 = CORDIC_W'(op_a) <<< TRIG_SHR;

    always_comb
    begin
        prod_next = a_reg * b_reg;

        div_shift = {rem_reg, quot_reg[DIV_BITS-1]};
        div_ge    = div_shift >= {1'b0, dvs_reg};
        rem_next  = div_ge ? DATA_W'(div_shift - {1'b0, dvs_reg}) : div_shift[DATA_W-1:0];
        quot_next = {quot_reg[DIV_BITS-2:0], div_ge};

        w_thr   = CORDIC_W'(WRAP_M) << (4'(WRAP_STEPS - 1) - cnt_reg[3:0]);
        wt_next = (wt_reg >= w_thr) ? (wt_reg - w_thr) : wt_reg;

        xs = cx_reg >>> cnt_reg[4:0];
        ys = cy_reg >>> cnt_reg[4:0];
        at = $signed({4'b0, atan_q30(cnt_reg[4:0])});
        if (!cz_reg[CORDIC_W-1])
        begin
            cx_next = cx_reg - ys;
            cy_next = cy_reg + xs;
            cz_next = cz_reg - at;
        end
        else
        begin
            cx_next = cx_reg + ys;
            cy_next = cy_reg - xs;
            cz_next = cz_reg + at;
        end
    end

    // result of the finishing operation
    always_comb
    begin
        mul_q    = prod_reg[2*DATA_W-1:FRAC_BITS];
        sin_full = neg_reg ? -cy_reg : cy_reg;
        cos_full = neg_reg ? -cx_reg : cx_reg;
        sum_s    = (cmd_reg.op == OP_SUB)
                   ? ({a_reg[DATA_W-1], a_reg} - {b_reg[DATA_W-1], b_reg})
                   : ({a_reg[DATA_W-1], a_reg} + {b_reg[DATA_W-1], b_reg});
        wr_ovf   = 1'b0;
        wr2_val  = DATA_W'(cos_full >>> TRIG_SHR);
        unique case (cmd_reg.op)
            OP_MUL:
            begin
                if (!((&mul_q[DIV_BITS-1:DATA_W-1]) || !(|mul_q[DIV_BITS-1:DATA_W-1])))
                begin
                    wr_ovf = 1'b1;
                    wr_val = mul_q[DIV_BITS-1] ? Q_MIN : Q_MAX;
                end
                else
                    wr_val = mul_q[DATA_W-1:0];
            end
            OP_DIV:
            begin
                if (dz_reg)
                begin
                    wr_ovf = 1'b1;
                    wr_val = '0;
                end
                else if (qneg_reg)
                begin
                    wr_ovf = quot_reg > DIV_BITS'(Q_MAX) + 1'b1;
                    wr_val = wr_ovf ? Q_MIN : DATA_W'(-quot_reg);
                end
                else
                begin
                    wr_ovf = quot_reg > DIV_BITS'(Q_MAX);
                    wr_val = wr_ovf ? Q_MAX : DATA_W'(quot_reg);
                end
            end
            OP_WRAP:   wr_val = DATA_W'(wt_reg - CORDIC_W'(PI_F));
            OP_SINCOS: wr_val = DATA_W'(sin_full >>> TRIG_SHR);
            default:
            begin
                if (sum_s[DATA_W] != sum_s[DATA_W-1])
                begin
                    wr_ovf = 1'b1;
                    wr_val = sum_s[DATA_W] ? Q_MIN : Q_MAX;
                end
                else
                    wr_val = sum_s[DATA_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.start_item)
                ovf_reg <= 1'b0;
            else if (wr_en && wr_ovf)
                ovf_reg <= 1'b1;
            if (dp_cmd.go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (wr_en)
                run_reg <= 1'b0;
            else if (run_reg)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // operation payload
    always_ff @(posedge clk)
    begin
        if (dp_cmd.go)
        begin
            cmd_reg  <= dp_cmd.cmd;
            a_reg    <= op_a;
            b_reg    <= op_b;
            qneg_reg <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
            dz_reg   <= (op_b == '0);
            dvs_reg  <= d_mag;
            rem_reg  <= '0;
            quot_reg <= {n_mag, FRAC_BITS'(0)};
            wt_reg   <= CORDIC_W'(op_a) + CORDIC_W'(PI_F)
                        + (CORDIC_W'(WRAP_M) << (WRAP_STEPS - 1));
            cx_reg   <= GAIN_Q30;
            cy_reg   <= '0;
            if (z0 > HALF_PI_Q30)
            begin
                cz_reg  <= z0 - PI_Q30;
                neg_reg <= 1'b1;
            end
            else if (z0 < -HALF_PI_Q30)
            begin
                cz_reg  <= z0 + PI_Q30;
                neg_reg <= 1'b1;
            end
            else
            begin
                cz_reg  <= z0;
                neg_reg <= 1'b0;
            end
        end
        else if (run_reg && !wr_en)
        begin
            prod_reg <= prod_next;
            if (cmd_reg.op == OP_DIV)
            begin
                rem_reg  <= rem_next;
                quot_reg <= quot_next;
            end
            if (cmd_reg.op == OP_WRAP)
                wt_reg <= wt_next;
            if (cmd_reg.op == OP_SINCOS)
            begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                cz_reg <= cz_next;
            end
        end
    end

    // pendulum state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg <= '0;
            a2_reg <= '0;
            r1_reg <= '0;
            r2_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (cmd_reg.dst)
                ID_A1:   a1_reg <= wr_val;
                ID_A2:   a2_reg <= wr_val;
                ID_R1:   r1_reg <= wr_val;
                ID_R2:   r2_reg <= wr_val;
                default: ;
            endcase
        end
    end

    // scratch values
    always_ff @(posedge clk)
    begin
        if (dp_cmd.start_item)
        begin
            u_reg  <= DATA_W'((1 << FRAC_BITS) + cfg.upper_mass + cfg.lower_mass);
            // five times the frame time, wide enough for the largest input
            dt_reg <= DATA_W'({2'b00, frame_time, 2'b00} + {4'b0000, frame_time});
        end
        if (wr_en)
        begin
            unique case (cmd_reg.dst)
                ID_S1:   s1_reg  <= wr_val;
                ID_S2:   s2_reg  <= wr_val;
                ID_SD:   sd_reg  <= wr_val;
                ID_CD:   cd_reg  <= wr_val;
                ID_W1:   w1_reg  <= wr_val;
                ID_W2:   w2_reg  <= wr_val;
                ID_DEN:  den_reg <= wr_val;
                ID_T0:   t0_reg  <= wr_val;
                ID_T1:   t1_reg  <= wr_val;
                ID_T2:   t2_reg  <= wr_val;
                ID_T3:   t3_reg  <= wr_val;
                ID_JX:   jx_reg  <= wr_val;
                ID_JY:   jy_reg  <= wr_val;
                ID_TX:   tx_reg  <= wr_val;
                ID_TY:   ty_reg  <= wr_val;
                default: ;
            endcase
        end
        if (wr2_en)
        begin
            unique case (cmd_reg.dst2)
                ID_C1:   c1_reg <= wr2_val;
                ID_C2:   c2_reg <= wr2_val;
                ID_CD:   cd_reg <= wr2_val;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        result.upper_angle = a1_reg[18:0];
        result.lower_angle = a2_reg[18:0];
        result.upper_rate  = r1_reg;
        result.lower_rate  = r2_reg;
        result.joint_x     = jx_reg;
        result.joint_y     = jy_reg;
        result.tip_x       = tx_reg;
        result.tip_y       = ty_reg;
        result.overflow    = ovf_reg;
    end

endmodule
